// File: hw/rtl/binary_trie_longest_prefix_match_core_assert.svh
// assertion macros for the trie core
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_CORE_ASSERT_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BTLPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BTLPM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/btlpm_pkg.sv
`timescale 1ns / 1ps

package btlpm_pkg;

    localparam int ADDR_W             = 32;
    localparam int GW_W               = 32;
    localparam int LVL_W              = 6;
    localparam int MAX_LEN            = 32;
    localparam int DEFAULT_NODE_COUNT = 4096;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // prefix length = 32 minus index of lowest set bit, zero for an empty mask
    function automatic logic [LVL_W-1:0] prefix_len(input logic [ADDR_W-1:0] m);
        logic [ADDR_W-1:0] v;
        logic [LVL_W-1:0]  tz;
        v  = m;
        tz = '0;
        if (m == '0)
        begin
            return '0;
        end
        if (v[15:0] == '0)
        begin
            tz = tz + LVL_W'(16);
            v  = v >> 16;
        end
        if (v[7:0] == '0)
        begin
            tz = tz + LVL_W'(8);
            v  = v >> 8;
        end
        if (v[3:0] == '0)
        begin
            tz = tz + LVL_W'(4);
            v  = v >> 4;
        end
        if (v[1:0] == '0)
        begin
            tz = tz + LVL_W'(2);
            v  = v >> 2;
        end
        if (v[0] == 1'b0)
        begin
            tz = tz + LVL_W'(1);
        end
        return LVL_W'(MAX_LEN) - tz;
    endfunction

endpackage

// File: hw/rtl/btlpm_ram.sv
`timescale 1ns / 1ps

module btlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/binary_trie_longest_prefix_match_core.sv
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+------------------------------------
// in       | in_valid / in_ready  | cmd, address, mask, gateway
// out      | out_valid / out_ready| next_hop, pool_full
//
// lookup: one node memory read per level
// insert: at most one memory access per cycle, reads for the walk, writes for the new
//   nodes and the gateway
// reset: node 0 reads as empty until first written, nodes at or above the free
//   counter are never read, so no clearing pass is needed
// a finished result waits in the output register; the next transfer is taken meanwhile,
//   and the following result holds in the done state until that register frees

module binary_trie_longest_prefix_match_core
    import btlpm_pkg::*;
#(
    parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [ADDR_W-1:0] address,
    input  logic [ADDR_W-1:0] mask,
    input  logic [GW_W-1:0]   gateway,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [GW_W-1:0]   next_hop,
    output logic              pool_full
);

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int FREE_W  = $clog2(NODE_COUNT + 1);
    localparam int NODE_DW = 2 * NODE_W + GW_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_WALK,
        S_CHECK,
        S_ALLOC,
        S_DONE
    } state_t;

    // sequencer state
    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;          // node being read or written
    logic [ADDR_W-1:0]   addr_reg, addr_next;        // address, consumed msb first
    logic [GW_W-1:0]     gw_reg, gw_next;
    logic [LVL_W-1:0]    len_reg, len_next;          // prefix length of the insert
    logic [LVL_W-1:0]    lvl_reg, lvl_next;          // levels walked so far
    logic [GW_W-1:0]     best_reg, best_next;        // longest gateway met so far
    logic [NODE_DW-1:0]  node_reg, node_next;        // last node read on the walk
    logic [FREE_W-1:0]   free_reg, free_next;        // next unused node
    logic                root_valid_reg, root_valid_next;
    logic [GW_W-1:0]     res_hop_reg, res_hop_next;
    logic                res_full_reg, res_full_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [GW_W-1:0]     next_hop_reg, next_hop_next;
    logic                pool_full_reg, pool_full_next;

    // node memory ports
    logic                rd_en;
    logic [NODE_W-1:0]   rd_addr;
    logic [NODE_DW-1:0]  rd_data;
    logic                wr_en;
    logic [NODE_W-1:0]   wr_addr;
    logic [NODE_DW-1:0]  wr_data;

    // decoded node
    logic [NODE_DW-1:0]  node_data;
    logic [NODE_W-1:0]   link0;
    logic [NODE_W-1:0]   link1;
    logic [GW_W-1:0]     node_gw;
    logic [NODE_W-1:0]   child;
    logic [GW_W-1:0]     best_upd;
    logic [LVL_W-1:0]    need;
    logic [FREE_W:0]     free_sum;
    logic [NODE_W-1:0]   new_idx;
    logic                out_free;

    btlpm_ram #(
        .WIDTH (NODE_DW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // root reads as empty until its first write; other nodes are written on allocation
    assign node_data = (cur_reg == '0 && !root_valid_reg) ? '0 : rd_data;
    assign link0     = node_data[NODE_DW-1 -: NODE_W];
    assign link1     = node_data[GW_W +: NODE_W];
    assign node_gw   = node_data[GW_W-1:0];
    assign child     = addr_reg[ADDR_W-1] ? link1 : link0;
    assign best_upd  = (node_gw != '0) ? node_gw : best_reg;

    // nodes still missing on the insert path and the pool check
    assign need      = len_reg - lvl_reg;
    assign free_sum  = {1'b0, free_reg} + (FREE_W + 1)'(need);
    assign new_idx   = free_reg[NODE_W-1:0];

    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        addr_next       = addr_reg;
        gw_next         = gw_reg;
        len_next        = len_reg;
        lvl_next        = lvl_reg;
        best_next       = best_reg;
        node_next       = node_reg;
        free_next       = free_reg;
        root_valid_next = root_valid_reg;
        res_hop_next    = res_hop_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg;
        next_hop_next   = next_hop_reg;
        pool_full_next  = pool_full_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = '0;

        // output transfer frees the register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next = address;
                    gw_next   = gateway;
                    len_next  = prefix_len(mask);
                    lvl_next  = '0;
                    cur_next  = '0;
                    best_next = '0;
                    rd_en     = 1'b1;
                    rd_addr   = '0;
                    state_next = (cmd == CMD_LOOKUP) ? S_LOOKUP : S_WALK;
                end
            end

            S_LOOKUP:
            begin
                best_next = best_upd;
                if (lvl_reg == LVL_W'(MAX_LEN) || child == '0)
                begin
                    res_hop_next  = best_upd;
                    res_full_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = child;
                    cur_next  = child;
                    addr_next = addr_reg << 1;
                    lvl_next  = lvl_reg + LVL_W'(1);
                end
            end

            S_WALK:
            begin
                node_next = node_data;
                if (lvl_reg == len_reg || child == '0)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = child;
                    cur_next  = child;
                    addr_next = addr_reg << 1;
                    lvl_next  = lvl_reg + LVL_W'(1);
                end
            end

            S_CHECK:
            begin
                res_hop_next = '0;
                if (free_sum > (FREE_W + 1)'(NODE_COUNT))
                begin
                    // pool too small for the whole path, nothing is written
                    res_full_next = 1'b1;
                    state_next    = S_DONE;
                end
                else if (need == '0)
                begin
                    // path already there, only the gateway changes
                    res_full_next = 1'b0;
                    wr_en         = 1'b1;
                    wr_data       = {node_reg[NODE_DW-1:GW_W], gw_reg};
                    state_next    = S_DONE;
                end
                else
                begin
                    // hook the first new node below the last existing one
                    res_full_next = 1'b0;
                    wr_en         = 1'b1;
                    wr_data       = node_reg;
                    if (addr_reg[ADDR_W-1])
                    begin
                        wr_data[GW_W +: NODE_W] = new_idx;
                    end
                    else
                    begin
                        wr_data[NODE_DW-1 -: NODE_W] = new_idx;
                    end
                    cur_next   = new_idx;
                    free_next  = free_reg + FREE_W'(1);
                    addr_next  = addr_reg << 1;
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = S_ALLOC;
                end
            end

            S_ALLOC:
            begin
                wr_en = 1'b1;
                if (lvl_reg == len_reg)
                begin
                    wr_data    = {{(2 * NODE_W){1'b0}}, gw_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    if (addr_reg[ADDR_W-1])
                    begin
                        wr_data[GW_W +: NODE_W] = new_idx;
                    end
                    else
                    begin
                        wr_data[NODE_DW-1 -: NODE_W] = new_idx;
                    end
                    cur_next  = new_idx;
                    free_next = free_reg + FREE_W'(1);
                    addr_next = addr_reg << 1;
                    lvl_next  = lvl_reg + LVL_W'(1);
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    next_hop_next  = res_hop_reg;
                    pool_full_next = res_full_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && wr_addr == '0)
        begin
            root_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            addr_reg       <= '0;
            gw_reg         <= '0;
            len_reg        <= '0;
            lvl_reg        <= '0;
            best_reg       <= '0;
            node_reg       <= '0;
            free_reg       <= FREE_W'(1);
            root_valid_reg <= 1'b0;
            res_hop_reg    <= '0;
            res_full_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            next_hop_reg   <= '0;
            pool_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            addr_reg       <= addr_next;
            gw_reg         <= gw_next;
            len_reg        <= len_next;
            lvl_reg        <= lvl_next;
            best_reg       <= best_next;
            node_reg       <= node_next;
            free_reg       <= free_next;
            root_valid_reg <= root_valid_next;
            res_hop_reg    <= res_hop_next;
            res_full_reg   <= res_full_next;
            out_valid_reg  <= out_valid_next;
            next_hop_reg   <= next_hop_next;
            pool_full_reg  <= pool_full_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign next_hop  = next_hop_reg;
    assign pool_full = pool_full_reg;

    `include "binary_trie_longest_prefix_match_core_assert.svh"

    // free counter stays within the pool and never hands out the root
    `BTLPM_ASSERT_IMP(a_free_range, clk, rst_n, 1'b1,
        free_reg != '0 && free_reg <= FREE_W'(NODE_COUNT), "free counter out of range")

    // only allocated nodes are ever read
    `BTLPM_ASSERT_IMP(a_read_allocated, clk, rst_n, rd_en,
        FREE_W'(rd_addr) < free_reg, "read of an unallocated node")

    // writes only happen once the pool check has passed
    `BTLPM_ASSERT_IMP(a_write_phase, clk, rst_n, wr_en,
        state_reg == S_CHECK || state_reg == S_ALLOC, "node write outside insert phase")

    // allocation writes always target the node just taken from the pool
    `BTLPM_ASSERT_IMP(a_alloc_target, clk, rst_n, state_reg == S_ALLOC,
        wr_addr == NODE_W'(free_reg - FREE_W'(1)), "allocation write to wrong node")

    // a refused insert leaves the free counter untouched
    `BTLPM_ASSERT_NXT(a_refuse_atomic, clk, rst_n,
        state_reg == S_CHECK && free_sum > (FREE_W + 1)'(NODE_COUNT),
        $stable(free_reg) && res_full_reg, "refused insert changed the pool")

endmodule
